[rtl/fip_pkg.sv]
// Shared types, codes and constants for the frame impairment policy block.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
package fip_pkg;

  // Defaults of the top-level parameters.
  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int HANDLE_WIDTH_DEF = 16;
  localparam int HANDLE_MAX_W     = 64;

  // Generator constants.
  localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_A  = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_B  = 64'h94D049BB133111EB;
  localparam logic [9:0]  PERMILLE_MAX = 10'd1000;

  // Configuration register indexes.
  localparam logic [2:0] REG_ENABLED      = 3'd0;
  localparam logic [2:0] REG_SEED         = 3'd1;
  localparam logic [2:0] REG_DROP_PM      = 3'd2;
  localparam logic [2:0] REG_DUP_PM       = 3'd3;
  localparam logic [2:0] REG_DEFER_PM     = 3'd4;
  localparam logic [2:0] REG_DEFER_TICKS  = 3'd5;
  localparam logic [2:0] REG_MAX_DEFERRED = 3'd6;

  // Result kinds.
  localparam logic [2:0] KIND_DELIVER  = 3'd0;
  localparam logic [2:0] KIND_DROP     = 3'd1;
  localparam logic [2:0] KIND_DUP      = 3'd2;
  localparam logic [2:0] KIND_DEFER    = 3'd3;
  localparam logic [2:0] KIND_QFULL    = 3'd4;
  localparam logic [2:0] KIND_RELEASED = 3'd5;

  // Classes that the front end assigns to a frame.
  localparam logic [1:0] CLS_DELIVER = 2'd0;
  localparam logic [1:0] CLS_DROP    = 2'd1;
  localparam logic [1:0] CLS_DUP     = 2'd2;
  localparam logic [1:0] CLS_DEFER   = 2'd3;

  // Configuration held at the top level.
  typedef struct packed {
    logic        enabled;
    logic [9:0]  drop_pm;
    logic [9:0]  dup_pm;
    logic [9:0]  defer_pm;
    logic [15:0] defer_ticks;
    logic [4:0]  max_deferred;
  } cfg_t;

  // Command word passed from the front end to the back end.
  typedef struct packed {
    logic                    rel;
    logic [1:0]              cls;
    logic [HANDLE_MAX_W-1:0] handle;
    logic [31:0]             seq;
    logic [63:0]             tick;
  } cmd_t;

  // Clamp a permille value to 1000.
  function automatic logic [9:0] clamp_pm(input logic [9:0] v);
    return (v > PERMILLE_MAX) ? PERMILLE_MAX : v;
  endfunction

endpackage

[rtl/fip_rng.sv]
// Generator unit: steps the mixing generator and reduces its output modulo 1000.
// Uses one shared 32x32 multiplier for both mixing passes and a byte-wise remainder.
`timescale 1ns / 1ps
module fip_rng (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_load,
  input  logic [63:0] seed_val,
  input  logic        start,
  output logic        done,
  output logic [9:0]  roll
);
  import fip_pkg::*;

  localparam logic [1:0] R_IDLE = 2'd0;
  localparam logic [1:0] R_MUL  = 2'd1;
  localparam logic [1:0] R_MOD  = 2'd2;
  localparam logic [1:0] R_DONE = 2'd3;

  logic [1:0]  rstate;
  logic [63:0] gen_state;
  logic [63:0] z;
  logic [63:0] acc;
  logic        pass;
  logic [1:0]  ph;
  logic [2:0]  bc;
  logic [9:0]  r;

  logic [63:0] st_next;
  logic [63:0] kmul;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] prod;
  logic [63:0] acc_next;
  logic [17:0] mod_in;

  // Remainder of a value below 256000 by 1000, one restoring step per bit.
  function automatic logic [9:0] mod1000(input logic [17:0] x);
    logic [17:0] v;
    logic [17:0] d;
    v = x;
    for (int k = 7; k >= 0; k--) begin
      d = 18'(PERMILLE_MAX) << k;
      if (v >= d) begin
        v = v - d;
      end
    end
    return v[9:0];
  endfunction

  // Operand selection for the three partial products of a 64-bit low product.
  always_comb begin
    st_next = gen_state + GOLDEN;
    kmul    = pass ? MIX_B : MIX_A;
    case (ph)
      2'd0: begin
        op_a = z[31:0];
        op_b = kmul[31:0];
      end
      2'd1: begin
        op_a = z[63:32];
        op_b = kmul[31:0];
      end
      default: begin
        op_a = z[31:0];
        op_b = kmul[63:32];
      end
    endcase
    prod     = op_a * op_b;
    acc_next = acc + {prod[31:0], 32'd0};
    mod_in   = {r, z[63:56]};
  end

  assign done = (rstate == R_DONE);
  assign roll = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      rstate    <= R_IDLE;
      gen_state <= '0;
    end else begin
      if (seed_load) begin
        gen_state <= seed_val;
      end
      case (rstate)
        R_IDLE: begin
          if (start) begin
            gen_state <= st_next;
            z         <= st_next ^ (st_next >> 30);
            ph        <= 2'd0;
            pass      <= 1'b0;
            rstate    <= R_MUL;
          end
        end
        R_MUL: begin
          if (ph == 2'd0) begin
            acc <= prod;
            ph  <= 2'd1;
          end else if (ph == 2'd1) begin
            acc <= acc_next;
            ph  <= 2'd2;
          end else begin
            ph <= 2'd0;
            if (!pass) begin
              z    <= acc_next ^ (acc_next >> 27);
              pass <= 1'b1;
            end else begin
              z      <= acc_next ^ (acc_next >> 31);
              r      <= '0;
              bc     <= '0;
              rstate <= R_MOD;
            end
          end
        end
        R_MOD: begin
          // Fold in one byte, most significant first.
          r  <= mod1000(mod_in);
          z  <= z << 8;
          bc <= bc + 3'd1;
          if (bc == 3'd7) begin
            rstate <= R_DONE;
          end
        end
        default: begin
          rstate <= R_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/fip_front.sv]
// Front end: accepts input words, numbers frames and classifies them by roll.
// Depends on fip_pkg and fip_rng; hands one command word at a time to the queue.
`timescale 1ns / 1ps
module fip_front #(
  parameter int HANDLE_WIDTH = fip_pkg::HANDLE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    func,
  input  logic [63:0]             current_tick,
  input  logic [HANDLE_WIDTH-1:0] frame_handle,
  input  fip_pkg::cfg_t           cfg,
  input  logic                    seed_load,
  input  logic [63:0]             seed_val,
  input  logic                    q_full,
  output logic                    push,
  output fip_pkg::cmd_t           cmd
);
  import fip_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_WAIT = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]              fstate;
  logic                    c_rel;
  logic [1:0]              c_cls;
  logic [63:0]             c_tick;
  logic [HANDLE_WIDTH-1:0] c_handle;
  logic [31:0]             seq;

  logic        accept;
  logic        rng_start;
  logic        rng_done;
  logic [9:0]  roll;
  logic [11:0] t1;
  logic [11:0] t2;
  logic [11:0] t3;
  logic [1:0]  roll_cls;

  fip_rng u_rng (
    .clk       (clk),
    .rst       (rst),
    .seed_load (seed_load),
    .seed_val  (seed_val),
    .start     (rng_start),
    .done      (rng_done),
    .roll      (roll)
  );

  assign in_stall  = (fstate != F_IDLE);
  assign accept    = in_valid && (fstate == F_IDLE);
  assign rng_start = accept && !func && cfg.enabled;

  // Cumulative thresholds and the class of the roll.
  always_comb begin
    t1 = 12'(clamp_pm(cfg.drop_pm));
    t2 = t1 + 12'(clamp_pm(cfg.dup_pm));
    t3 = t2 + 12'(clamp_pm(cfg.defer_pm));
    if (12'(roll) < t1) begin
      roll_cls = CLS_DROP;
    end else if (12'(roll) < t2) begin
      roll_cls = CLS_DUP;
    end else if (12'(roll) < t3) begin
      roll_cls = CLS_DEFER;
    end else begin
      roll_cls = CLS_DELIVER;
    end
  end

  assign push       = (fstate == F_PUSH) && !q_full;
  assign cmd.rel    = c_rel;
  assign cmd.cls    = c_cls;
  assign cmd.handle = HANDLE_MAX_W'(c_handle);
  assign cmd.seq    = seq;
  assign cmd.tick   = c_tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate <= F_IDLE;
      seq    <= '0;
    end else begin
      case (fstate)
        F_IDLE: begin
          if (accept) begin
            c_rel    <= func;
            c_tick   <= current_tick;
            c_handle <= frame_handle;
            c_cls    <= CLS_DELIVER;
            if (!func) begin
              seq <= seq + 32'd1;
            end
            fstate <= rng_start ? F_WAIT : F_PUSH;
          end
        end
        F_WAIT: begin
          if (rng_done) begin
            c_cls  <= roll_cls;
            fstate <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            fstate <= F_IDLE;
          end
        end
        default: begin
          fstate <= F_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/fip_cmdq.sv]
// Two-entry command queue between the front end and the back end.
// Depends on fip_pkg for the command word type.
`timescale 1ns / 1ps
module fip_cmdq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fip_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          nonempty,
  output fip_pkg::cmd_t head
);
  import fip_pkg::*;

  cmd_t       ent [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign full     = (cnt == 2'd2);
  assign nonempty = (cnt != 2'd0);
  assign head     = ent[rp];

  // Entries carry payload only; pointers and fill are reset.
  always_ff @(posedge clk) begin
    if (push) begin
      ent[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

[rtl/fip_back.sv]
// Back end: carries out commands, holds the deferred-frame queue, drives results.
// Depends on fip_pkg; the queue is a memory with a registered read port.
`timescale 1ns / 1ps
module fip_back #(
  parameter int QUEUE_DEPTH  = fip_pkg::QUEUE_DEPTH_DEF,
  parameter int HANDLE_WIDTH = fip_pkg::HANDLE_WIDTH_DEF,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  input  fip_pkg::cmd_t           q_head,
  output logic                    q_pop,
  input  logic [15:0]             defer_ticks,
  input  logic [4:0]              max_deferred,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [2:0]              kind,
  output logic                    frame_valid,
  output logic [HANDLE_WIDTH-1:0] frame_handle_out,
  output logic [31:0]             sequence_res,
  output logic [63:0]             release_tick,
  output logic [CW-1:0]           queue_depth,
  output logic                    last
);
  import fip_pkg::*;

  localparam int IW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CMPW = (CW > 5) ? CW : 5;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_OUT  = 3'd1;
  localparam logic [2:0] B_P1A  = 3'd2;
  localparam logic [2:0] B_P1B  = 3'd3;
  localparam logic [2:0] B_P2A  = 3'd4;
  localparam logic [2:0] B_P2B  = 3'd5;

  logic [63:0]             due_mem [QUEUE_DEPTH];
  logic [HANDLE_WIDTH-1:0] hdl_mem [QUEUE_DEPTH];
  logic [63:0]             rd_due;
  logic [HANDLE_WIDTH-1:0] rd_hdl;

  logic [2:0]              bst;
  logic [CW-1:0]           count;
  logic [CW-1:0]           i;
  logic [CW-1:0]           wr;
  logic [CW-1:0]           keep;
  logic [CW-1:0]           ndue;
  logic [CW-1:0]           emitted;
  logic [63:0]             cur_tick;
  logic                    dup2;

  logic [2:0]              p_kind;
  logic                    p_fv;
  logic [HANDLE_WIDTH-1:0] p_handle;
  logic [31:0]             p_seq;
  logic [63:0]             p_rt;
  logic [CW-1:0]           p_depth;
  logic                    p_last;

  logic                    slot_free;
  logic [15:0]             delay;
  logic [63:0]             due;
  logic [CMPW-1:0]         cap;
  logic                    defer_ok;
  logic                    kept;
  logic                    at_end;
  logic                    mem_we;
  logic [IW-1:0]           mem_wa;
  logic [63:0]             mem_wdue;
  logic [HANDLE_WIDTH-1:0] mem_whdl;
  logic                    rel_load;

  // Defer arithmetic, capacity check and release comparison.
  always_comb begin
    slot_free = !out_valid || !out_stall;
    q_pop     = (bst == B_IDLE) && q_valid;
    delay     = (defer_ticks == 16'd0) ? 16'd1 : defer_ticks;
    due       = q_head.tick + 64'(delay);
    cap       = (CMPW'(max_deferred) < CMPW'(QUEUE_DEPTH)) ?
                CMPW'(max_deferred) : CMPW'(QUEUE_DEPTH);
    defer_ok  = (CMPW'(count) < cap);
    kept      = (rd_due > cur_tick);
    at_end    = (i == count - CW'(1));
    rel_load  = (bst == B_P2B) && !kept && slot_free;
  end

  // Queue write: a new deferred frame, or a kept entry moved down.
  always_comb begin
    mem_we   = 1'b0;
    mem_wa   = count[IW-1:0];
    mem_wdue = due;
    mem_whdl = HANDLE_WIDTH'(q_head.handle);
    if (q_pop && !q_head.rel && (q_head.cls == CLS_DEFER) && defer_ok) begin
      mem_we = 1'b1;
    end else if ((bst == B_P2B) && kept) begin
      mem_we   = 1'b1;
      mem_wa   = wr[IW-1:0];
      mem_wdue = rd_due;
      mem_whdl = rd_hdl;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      due_mem[mem_wa] <= mem_wdue;
      hdl_mem[mem_wa] <= mem_whdl;
    end
    rd_due <= due_mem[i[IW-1:0]];
    rd_hdl <= hdl_mem[i[IW-1:0]];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((bst == B_OUT) && slot_free) begin
      out_valid        <= 1'b1;
      kind             <= p_kind;
      frame_valid      <= p_fv;
      frame_handle_out <= p_handle;
      sequence_res     <= p_seq;
      release_tick     <= p_rt;
      queue_depth      <= p_depth;
      last             <= p_last;
    end else if (rel_load) begin
      out_valid        <= 1'b1;
      kind             <= KIND_RELEASED;
      frame_valid      <= 1'b1;
      frame_handle_out <= rd_hdl;
      sequence_res     <= '0;
      release_tick     <= '0;
      queue_depth      <= keep;
      last             <= (emitted + CW'(1) == ndue);
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Command sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      bst   <= B_IDLE;
      count <= '0;
      dup2  <= 1'b0;
    end else begin
      case (bst)
        B_IDLE: begin
          if (q_valid) begin
            cur_tick <= q_head.tick;
            if (q_head.rel) begin
              i    <= '0;
              keep <= '0;
              if (count != '0) begin
                bst <= B_P1A;
              end
            end else begin
              p_seq    <= q_head.seq;
              p_rt     <= '0;
              p_fv     <= 1'b0;
              p_handle <= '0;
              p_last   <= 1'b1;
              p_depth  <= count;
              dup2     <= 1'b0;
              case (q_head.cls)
                CLS_DROP: begin
                  p_kind <= KIND_DROP;
                end
                CLS_DUP: begin
                  p_kind   <= KIND_DUP;
                  p_fv     <= 1'b1;
                  p_handle <= HANDLE_WIDTH'(q_head.handle);
                  p_last   <= 1'b0;
                  dup2     <= 1'b1;
                end
                CLS_DEFER: begin
                  if (defer_ok) begin
                    p_kind  <= KIND_DEFER;
                    p_rt    <= due;
                    p_depth <= count + CW'(1);
                    count   <= count + CW'(1);
                  end else begin
                    p_kind <= KIND_QFULL;
                  end
                end
                default: begin
                  p_kind   <= KIND_DELIVER;
                  p_fv     <= 1'b1;
                  p_handle <= HANDLE_WIDTH'(q_head.handle);
                end
              endcase
              bst <= B_OUT;
            end
          end
        end
        B_OUT: begin
          if (slot_free) begin
            if (dup2) begin
              dup2   <= 1'b0;
              p_last <= 1'b1;
            end else begin
              bst <= B_IDLE;
            end
          end
        end
        B_P1A: begin
          bst <= B_P1B;
        end
        B_P1B: begin
          // First pass counts the entries that stay.
          if (at_end) begin
            i       <= '0;
            wr      <= '0;
            emitted <= '0;
            keep    <= keep + CW'(kept);
            ndue    <= count - keep - CW'(kept);
            bst     <= ((keep + CW'(kept)) == count) ? B_IDLE : B_P2A;
          end else begin
            keep <= keep + CW'(kept);
            i    <= i + CW'(1);
            bst  <= B_P1A;
          end
        end
        B_P2A: begin
          bst <= B_P2B;
        end
        B_P2B: begin
          // Second pass emits due entries and compacts the rest.
          if (kept || slot_free) begin
            if (kept) begin
              wr <= wr + CW'(1);
            end else begin
              emitted <= emitted + CW'(1);
            end
            if (at_end) begin
              count <= keep;
              bst   <= B_IDLE;
            end else begin
              i   <= i + CW'(1);
              bst <= B_P2A;
            end
          end
        end
        default: begin
          bst <= B_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/frame_impairment_policy.sv]
// Top level of the frame impairment policy: configuration registers, front end,
// command queue and back end. Depends on fip_pkg, fip_front, fip_cmdq, fip_back.
//
//   Channel | Handshake             | Payload
//   --------+-----------------------+----------------------------------------------
//   in      | in_valid / in_stall   | func, current_tick, frame_handle
//   out     | out_valid / out_stall | kind, frame_valid, frame_handle_out,
//           |                       | sequence_res, release_tick, queue_depth, last
//   cfg     | cfg_we                | cfg_index, cfg_data
//
// The front end takes one word at a time. A frame with impairment on passes through
// the shared 32x32 multiplier, then the byte-wise remainder by 1000, then the hand-over
// of the roll and the push; other words go straight to the push.
// A release makes two passes over the queue memory in the back end, each entry
// read through the registered read port.
// The two-entry command queue lets the front end classify while the back end works.
// Reset is synchronous and clears control state; there is no clearing pass.
// A stalled result holds in the output register; the back end waits on it.
`timescale 1ns / 1ps
module frame_impairment_policy #(
  parameter int QUEUE_DEPTH  = fip_pkg::QUEUE_DEPTH_DEF,
  parameter int HANDLE_WIDTH = fip_pkg::HANDLE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [2:0]                          cfg_index,
  input  logic [63:0]                         cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                func,
  input  logic [63:0]                         current_tick,
  input  logic [HANDLE_WIDTH-1:0]             frame_handle,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          kind,
  output logic                                frame_valid,
  output logic [HANDLE_WIDTH-1:0]             frame_handle_out,
  output logic [31:0]                         sequence_res,
  output logic [63:0]                         release_tick,
  output logic [$clog2(QUEUE_DEPTH + 1)-1:0]  queue_depth,
  output logic                                last
);
  import fip_pkg::*;

  cfg_t cfg;
  logic seed_load;
  logic q_full;
  logic push;
  cmd_t cmd;
  logic q_pop;
  logic q_valid;
  cmd_t q_head;

  assign seed_load = cfg_we && (cfg_index == REG_SEED);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled      <= 1'b0;
      cfg.drop_pm      <= '0;
      cfg.dup_pm       <= '0;
      cfg.defer_pm     <= '0;
      cfg.defer_ticks  <= 16'd1;
      cfg.max_deferred <= 5'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLED:      cfg.enabled      <= cfg_data[0];
        REG_DROP_PM:      cfg.drop_pm      <= cfg_data[9:0];
        REG_DUP_PM:       cfg.dup_pm       <= cfg_data[9:0];
        REG_DEFER_PM:     cfg.defer_pm     <= cfg_data[9:0];
        REG_DEFER_TICKS:  cfg.defer_ticks  <= cfg_data[15:0];
        REG_MAX_DEFERRED: cfg.max_deferred <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  fip_front #(
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .current_tick (current_tick),
    .frame_handle (frame_handle),
    .cfg          (cfg),
    .seed_load    (seed_load),
    .seed_val     (cfg_data),
    .q_full       (q_full),
    .push         (push),
    .cmd          (cmd)
  );

  fip_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (cmd),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_valid),
    .head     (q_head)
  );

  fip_back #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .defer_ticks      (cfg.defer_ticks),
    .max_deferred     (cfg.max_deferred),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .kind             (kind),
    .frame_valid      (frame_valid),
    .frame_handle_out (frame_handle_out),
    .sequence_res     (sequence_res),
    .release_tick     (release_tick),
    .queue_depth      (queue_depth),
    .last             (last)
  );

endmodule

[rtl/fip_check.sv]
// Port-level checker for the frame impairment policy, bound to the top level.
// Depends on fip_pkg for the result kinds.
`timescale 1ns / 1ps
module fip_check #(
  parameter int QUEUE_DEPTH  = fip_pkg::QUEUE_DEPTH_DEF,
  parameter int HANDLE_WIDTH = fip_pkg::HANDLE_WIDTH_DEF
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [2:0]                         kind,
  input logic                               frame_valid,
  input logic [HANDLE_WIDTH-1:0]            frame_handle_out,
  input logic [31:0]                        sequence_res,
  input logic [63:0]                        release_tick,
  input logic [$clog2(QUEUE_DEPTH + 1)-1:0] queue_depth,
  input logic                               last
);
  import fip_pkg::*;

  // A stalled result word stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame_handle_out) && $stable(kind)
      && $stable(last) && $stable(queue_depth))
    else $error("stalled result word changed");

  // A word without a frame carries no handle.
  a_nohandle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_valid |-> frame_handle_out == '0)
    else $error("handle on a word without a frame");

  // Released frames carry a frame, no sequence and no due tick.
  a_released: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_RELEASED) |->
      frame_valid && (sequence_res == 32'd0) && (release_tick == 64'd0))
    else $error("malformed release word");

  // Only a deferral reports a due tick.
  a_duetick: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != KIND_DEFER) |-> release_tick == 64'd0)
    else $error("due tick on a word that is not a deferral");

  // The reported queue depth never exceeds the queue.
  a_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(queue_depth) <= 32'(QUEUE_DEPTH))
    else $error("queue depth out of range");

endmodule

bind frame_impairment_policy fip_check #(
  .QUEUE_DEPTH  (QUEUE_DEPTH),
  .HANDLE_WIDTH (HANDLE_WIDTH)
) u_fip_check (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .kind             (kind),
  .frame_valid      (frame_valid),
  .frame_handle_out (frame_handle_out),
  .sequence_res     (sequence_res),
  .release_tick     (release_tick),
  .queue_depth      (queue_depth),
  .last             (last)
);
